>>> src/scbq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scbq_pkg
// Shared types and constants for the store checker bank queues unit.
// ----------------------------------------------------------------------------
package scbq_pkg;

    localparam int MAIN_DEPTH = 16;
    localparam int CORE_DEPTH = 8;
    localparam int NUM_CORES  = 4;

    localparam int MAIN_AW = $clog2(MAIN_DEPTH);
    localparam int CORE_AW = $clog2(CORE_DEPTH);
    localparam int CORE_IW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

    localparam logic [1:0] KIND_COMMIT   = 2'd0;
    localparam logic [1:0] KIND_COMPLETE = 2'd1;
    localparam logic [1:0] KIND_LOAD     = 2'd2;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    // Item handed from the front part to the back part.
    typedef struct packed {
        logic        op;
        logic        add_ok;
        logic [1:0]  kind;
        logic [1:0]  core;
        logic [31:0] seq;
        logic [47:0] addr;
    } work_t;

    typedef struct packed {
        logic        add_accepted;
        logic        load_valid;
        logic [31:0] load_seq;
        logic [47:0] load_address;
        logic        load_forward_hit;
        logic        retire_valid;
        logic [1:0]  retire_core;
        logic [31:0] retire_seq;
        logic [47:0] retire_address;
        logic        all_core_queues_empty;
    } result_t;

endpackage
`default_nettype wire

>>> src/scbq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scbq_front
// Accept items, classify adds and queue them toward the back part.
// ----------------------------------------------------------------------------
module scbq_front
    import scbq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire work_t in_item,
    output logic       q_valid,
    input  wire logic  q_ready,
    output work_t      q_item
);

    work_t      buf_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;
    work_t      cls;

    always_comb
    begin
        cls = in_item;
        cls.add_ok = (in_item.kind != 2'd3) &&
                     ({2'b00, in_item.core} < 4'(NUM_CORES));
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

>>> src/scbq_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scbq_back
// Main FIFO, per-core FIFOs, tick handling and retirement.
// ----------------------------------------------------------------------------
module scbq_back
    import scbq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_valid,
    output logic       q_ready,
    input  wire work_t q_item,
    output logic       out_valid,
    input  wire logic  out_ready,
    output result_t    out_res
);

    typedef enum logic [1:0] {ST_IDLE, ST_RETIRE, ST_OUT} state_t;

    state_t state_reg;

    // main FIFO
    logic [47:0] m_addr [MAIN_DEPTH];
    logic [31:0] m_seq  [MAIN_DEPTH];
    logic [1:0]  m_kind [MAIN_DEPTH];
    logic [1:0]  m_core [MAIN_DEPTH];
    logic [MAIN_AW-1:0] m_head_reg;
    logic [MAIN_AW:0]   m_cnt_reg;

    // core FIFOs
    logic [47:0] c_addr [NUM_CORES][CORE_DEPTH];
    logic [31:0] c_seq  [NUM_CORES][CORE_DEPTH];
    logic        c_rdy_reg [NUM_CORES][CORE_DEPTH];
    logic [CORE_AW-1:0] c_head_reg [NUM_CORES];
    logic [CORE_AW:0]   c_cnt_reg  [NUM_CORES];

    logic [15:0] lfsr_reg;
    result_t     res_reg;

    logic [MAIN_AW-1:0] m_tail;
    logic [47:0] h_addr;
    logic [31:0] h_seq;
    logic [1:0]  h_kind;
    logic [CORE_IW-1:0] h_core;
    logic [CORE_AW-1:0] c_tail;
    logic        hit;
    logic [CORE_DEPTH-1:0] in_q;
    logic [15:0] lfsr_next;
    logic [CORE_IW-1:0] start;
    logic        r_found;
    logic [CORE_IW-1:0] r_core;
    logic        empty_after;
    logic        empty_now;
    result_t     idle_res;
    result_t     retire_res;

    assign q_ready   = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_res   = res_reg;

    assign m_tail = MAIN_AW'(m_head_reg + m_cnt_reg[MAIN_AW-1:0]);
    assign h_addr = m_addr[m_head_reg];
    assign h_seq  = m_seq[m_head_reg];
    assign h_kind = m_kind[m_head_reg];
    assign h_core = CORE_IW'(m_core[m_head_reg]);
    assign c_tail = CORE_AW'(c_head_reg[h_core] + c_cnt_reg[h_core][CORE_AW-1:0]);

    always_comb
    begin
        hit = 1'b0;
        for (int k = 0; k < CORE_DEPTH; k++)
        begin
            in_q[k] = (CORE_AW'(CORE_AW'(k) - c_head_reg[h_core])
                       < c_cnt_reg[h_core]) || (c_cnt_reg[h_core] == CORE_DEPTH);
            if (in_q[k] && c_addr[h_core][k] == h_addr) hit = 1'b1;
        end
    end

    assign lfsr_next = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5],
                        lfsr_reg[15:1]};
    assign start = CORE_IW'(lfsr_reg % NUM_CORES);

    always_comb
    begin
        logic [CORE_IW:0] c;
        r_found = 1'b0;
        r_core  = '0;
        empty_after = 1'b1;
        for (int i = 0; i < NUM_CORES; i++)
        begin
            c = (CORE_IW+1)'(start) + (CORE_IW+1)'(i);
            if (c >= (CORE_IW+1)'(NUM_CORES)) c = c - (CORE_IW+1)'(NUM_CORES);
            if (!r_found && c_cnt_reg[c[CORE_IW-1:0]] != 0 &&
                c_rdy_reg[c[CORE_IW-1:0]][c_head_reg[c[CORE_IW-1:0]]])
            begin
                r_found = 1'b1;
                r_core  = c[CORE_IW-1:0];
            end
        end
        for (int i = 0; i < NUM_CORES; i++)
        begin
            if (c_cnt_reg[i] != 0 &&
                !(r_found && CORE_IW'(i) == r_core && c_cnt_reg[i] == 1))
                empty_after = 1'b0;
        end
    end

    // result beat as built in the idle and retire cycles
    always_comb
    begin
        empty_now = 1'b1;
        for (int i = 0; i < NUM_CORES; i++)
            if (c_cnt_reg[i] != 0)
                empty_now = 1'b0;
        idle_res = '0;
        if (q_item.op == OP_ADD)
        begin
            idle_res.add_accepted          = q_item.add_ok && (m_cnt_reg != MAIN_DEPTH);
            idle_res.all_core_queues_empty = empty_now;
        end
        else if (m_cnt_reg != 0 && h_kind != KIND_COMMIT && h_kind != KIND_COMPLETE)
        begin
            idle_res.load_valid       = 1'b1;
            idle_res.load_seq         = h_seq;
            idle_res.load_address     = h_addr;
            idle_res.load_forward_hit = hit;
        end
        retire_res = res_reg;
        if (r_found)
        begin
            retire_res.retire_valid   = 1'b1;
            retire_res.retire_core    = 2'(r_core);
            retire_res.retire_seq     = c_seq[r_core][c_head_reg[r_core]];
            retire_res.retire_address = c_addr[r_core][c_head_reg[r_core]];
        end
        retire_res.all_core_queues_empty = empty_after;
    end

    // payload writes
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid && q_item.op == OP_ADD &&
            q_item.add_ok && m_cnt_reg != MAIN_DEPTH)
        begin
            m_addr[m_tail] <= q_item.addr;
            m_seq[m_tail]  <= q_item.seq;
            m_kind[m_tail] <= q_item.kind;
            m_core[m_tail] <= q_item.core;
        end
        if (state_reg == ST_IDLE && q_valid && q_item.op == OP_TICK &&
            m_cnt_reg != 0 && h_kind == KIND_COMMIT && c_cnt_reg[h_core] != CORE_DEPTH)
        begin
            c_addr[h_core][c_tail] <= h_addr;
            c_seq[h_core][c_tail]  <= h_seq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            m_head_reg <= '0;
            m_cnt_reg  <= '0;
            lfsr_reg   <= LFSR_SEED;
            res_reg    <= '0;
            for (int c = 0; c < NUM_CORES; c++)
            begin
                c_head_reg[c] <= '0;
                c_cnt_reg[c]  <= '0;
                for (int k = 0; k < CORE_DEPTH; k++) c_rdy_reg[c][k] <= 1'b0;
            end
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        res_reg <= idle_res;
                        if (q_item.op == OP_ADD)
                        begin
                            if (q_item.add_ok && m_cnt_reg != MAIN_DEPTH)
                                m_cnt_reg <= m_cnt_reg + 1'b1;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            // handle main head
                            if (m_cnt_reg != 0)
                            begin
                                if (h_kind == KIND_COMMIT)
                                begin
                                    if (c_cnt_reg[h_core] != CORE_DEPTH)
                                    begin
                                        c_rdy_reg[h_core][c_tail] <= 1'b0;
                                        c_cnt_reg[h_core] <= c_cnt_reg[h_core] + 1'b1;
                                        m_head_reg <= MAIN_AW'(m_head_reg + 1'b1);
                                        m_cnt_reg  <= m_cnt_reg - 1'b1;
                                    end
                                end
                                else
                                begin
                                    if (h_kind == KIND_COMPLETE)
                                    begin
                                        for (int k = 0; k < CORE_DEPTH; k++)
                                            if (in_q[k] && c_seq[h_core][k] == h_seq)
                                                c_rdy_reg[h_core][k] <= 1'b1;
                                    end
                                    m_head_reg <= MAIN_AW'(m_head_reg + 1'b1);
                                    m_cnt_reg  <= m_cnt_reg - 1'b1;
                                end
                            end
                            lfsr_reg  <= lfsr_next;
                            state_reg <= ST_RETIRE;
                        end
                    end
                end
                ST_RETIRE:
                begin
                    res_reg <= retire_res;
                    if (r_found)
                    begin
                        c_rdy_reg[r_core][c_head_reg[r_core]] <= 1'b0;
                        c_head_reg[r_core] <= CORE_AW'(c_head_reg[r_core] + 1'b1);
                        c_cnt_reg[r_core]  <= c_cnt_reg[r_core] - 1'b1;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_ready) state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> src/store_checker_bank_queues_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// store_checker_bank_queues_unit
// Bank unit: shared main FIFO feeding per-core FIFOs with load forwarding
// checks and LFSR-started retirement.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat contents
// s_axis   in   tuser: operation, record_kind; tdata: core_id, seq_num,
//               packet_address
// m_axis   out  tdata: add_accepted .. all_core_queues_empty (see port comment)
//
// An add's result is built in the idle state; a tick handles the main head
// there and scans the updated core FIFOs for retirement in the retire state.
// The back part works one beat at a time; a 2-entry queue after the input
// keeps accepting while a result waits. Reset clears all control state and
// valid bits; the stored records themselves need no clearing.
// ----------------------------------------------------------------------------
module store_checker_bank_queues_unit
    import scbq_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // operation[0], record_kind[2:1], zero [7:3]
    input  wire logic [7:0]   s_axis_tuser,
    // core_id[1:0], seq_num[33:2], packet_address[81:34], zero [87:82]
    input  wire logic [87:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // add_accepted[0], load_valid[1], load_seq[33:2], load_address[81:34],
    // load_forward_hit[82], retire_valid[83], retire_core[85:84],
    // retire_seq[117:86], retire_address[165:118], all_core_queues_empty[166],
    // zero [167]
    output logic [167:0]      m_axis_tdata
);

    work_t   in_item, q_item;
    logic    q_valid, q_ready;
    result_t res;

    // unpack the incoming beat
    always_comb
    begin
        in_item        = '0;
        in_item.op     = s_axis_tuser[0];
        in_item.kind   = s_axis_tuser[2:1];
        in_item.core   = s_axis_tdata[1:0];
        in_item.seq    = s_axis_tdata[33:2];
        in_item.addr   = s_axis_tdata[81:34];
    end

    scbq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    scbq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // pack the outgoing beat, highest field first
    assign m_axis_tdata = {1'b0, res.all_core_queues_empty, res.retire_address,
                           res.retire_seq, res.retire_core, res.retire_valid,
                           res.load_forward_hit, res.load_address, res.load_seq,
                           res.load_valid, res.add_accepted};

endmodule
`default_nettype wire

>>> sim/scbq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scbq_checker
// Watches both stream channels of the bank queues unit, predicts each result
// beat from accepted input beats and compares the fields in order.
// ----------------------------------------------------------------------------
module scbq_checker
    import scbq_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         in_ready,
    input  wire logic [7:0]   in_user,
    input  wire logic [87:0]  in_data,
    input  wire logic         out_valid,
    input  wire logic         out_ready,
    input  wire logic [167:0] out_data,
    output int                fail_count,
    output int                pending,
    output int                loads_seen,
    output int                retires_seen,
    output int                hits_seen
);

    typedef struct {
        logic [47:0] addr;
        logic [31:0] seq;
        logic [1:0]  kind;
        logic [1:0]  core;
    } rec_t;

    rec_t        main_q[MAIN_DEPTH];
    int          main_head;
    int          main_cnt;
    logic [47:0] cq_addr[NUM_CORES][CORE_DEPTH];
    logic [31:0] cq_seq[NUM_CORES][CORE_DEPTH];
    logic        cq_rdy[NUM_CORES][CORE_DEPTH];
    int          cq_head[NUM_CORES];
    int          cq_cnt[NUM_CORES];
    logic [15:0] lfsr;
    result_t     expected_beats[$];

    function automatic logic queues_empty();
        for (int c = 0; c < NUM_CORES; c++)
            if (cq_cnt[c] != 0)
                return 1'b0;
        return 1'b1;
    endfunction

    // Lay out a result beat the way it appears on the output bus.
    function automatic logic [167:0] pack_res(result_t r);
        return {1'b0, r.all_core_queues_empty, r.retire_address, r.retire_seq,
                r.retire_core, r.retire_valid, r.load_forward_hit, r.load_address,
                r.load_seq, r.load_valid, r.add_accepted};
    endfunction

    // Advance the bank state by one input beat and return the result beat.
    function automatic result_t bank_step(logic [7:0] u, logic [87:0] d);
        result_t r;
        logic op;
        logic [1:0] kind, core;
        logic [31:0] seq;
        logic [47:0] addr;
        int q, k, st, c;
        logic hit, pop;
        r = '0;
        op = u[0];
        kind = u[2:1];
        core = d[1:0];
        seq = d[33:2];
        addr = d[81:34];
        if (op == OP_ADD) begin
            if (kind <= KIND_LOAD && core < NUM_CORES && main_cnt < MAIN_DEPTH) begin
                k = (main_head + main_cnt) % MAIN_DEPTH;
                main_q[k] = '{addr, seq, kind, core};
                main_cnt++;
                r.add_accepted = 1'b1;
            end
            r.all_core_queues_empty = queues_empty();
            return r;
        end
        if (main_cnt != 0) begin
            q = main_q[main_head].core % NUM_CORES;
            pop = 1'b1;
            if (main_q[main_head].kind == KIND_COMMIT) begin
                if (cq_cnt[q] < CORE_DEPTH) begin
                    k = (cq_head[q] + cq_cnt[q]) % CORE_DEPTH;
                    cq_addr[q][k] = main_q[main_head].addr;
                    cq_seq[q][k] = main_q[main_head].seq;
                    cq_rdy[q][k] = 1'b0;
                    cq_cnt[q]++;
                end else
                    pop = 1'b0;
            end else if (main_q[main_head].kind == KIND_COMPLETE) begin
                for (int i = 0; i < cq_cnt[q]; i++) begin
                    k = (cq_head[q] + i) % CORE_DEPTH;
                    if (cq_seq[q][k] == main_q[main_head].seq)
                        cq_rdy[q][k] = 1'b1;
                end
            end else begin
                hit = 1'b0;
                for (int i = 0; i < cq_cnt[q]; i++) begin
                    k = (cq_head[q] + i) % CORE_DEPTH;
                    if (cq_addr[q][k] == main_q[main_head].addr)
                        hit = 1'b1;
                end
                r.load_valid = 1'b1;
                r.load_seq = main_q[main_head].seq;
                r.load_address = main_q[main_head].addr;
                r.load_forward_hit = hit;
            end
            if (pop) begin
                main_head = (main_head + 1) % MAIN_DEPTH;
                main_cnt--;
            end
        end
        lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
        st = lfsr % NUM_CORES;
        for (int i = 0; i < NUM_CORES; i++) begin
            c = (st + i) % NUM_CORES;
            if (cq_cnt[c] != 0 && cq_rdy[c][cq_head[c]]) begin
                r.retire_valid = 1'b1;
                r.retire_core = c[1:0];
                r.retire_seq = cq_seq[c][cq_head[c]];
                r.retire_address = cq_addr[c][cq_head[c]];
                cq_rdy[c][cq_head[c]] = 1'b0;
                cq_head[c] = (cq_head[c] + 1) % CORE_DEPTH;
                cq_cnt[c]--;
                break;
            end
        end
        r.all_core_queues_empty = queues_empty();
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        logic [167:0] want_bits;
        if (!rst_n) begin
            main_head = 0;
            main_cnt = 0;
            lfsr = LFSR_SEED;
            for (int c = 0; c < NUM_CORES; c++) begin
                cq_head[c] = 0;
                cq_cnt[c] = 0;
                for (int i = 0; i < CORE_DEPTH; i++)
                    cq_rdy[c][i] = 1'b0;
            end
            expected_beats.delete();
            pending <= 0;
            fail_count <= 0;
            loads_seen <= 0;
            retires_seen <= 0;
            hits_seen <= 0;
        end else begin
            if (in_valid && in_ready)
                expected_beats.insert(expected_beats.size(), bank_step(in_user, in_data));
            if (out_valid && out_ready) begin
                if (expected_beats.size() == 0) begin
                    if (fail_count < 10)
                        $display("%t result beat with nothing expected: %h",
                                 $realtime, out_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_beats[0];
                    expected_beats.delete(0);
                    want_bits = pack_res(want);
                    if (out_data !== want_bits) begin
                        if (fail_count < 10)
                            $display("%t mismatch exp=%h got=%h", $realtime, want_bits,
                                     out_data);
                        fail_count <= fail_count + 1;
                    end
                    loads_seen <= loads_seen + want.load_valid;
                    retires_seen <= retires_seen + want.retire_valid;
                    hits_seen <= hits_seen + want.load_forward_hit;
                end
            end
            pending <= expected_beats.size();
        end
    end

endmodule

>>> sim/store_checker_bank_queues_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// store_checker_bank_queues_unit_test
// Drives add and tick beats into the bank queues unit with random gaps and
// back pressure; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module store_checker_bank_queues_unit_test;
    import scbq_pkg::*;

    localparam int WATCHDOG = 20000;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // operation[0], record_kind[2:1], zero [7:3]
    logic [7:0]   s_axis_tuser = '0;
    // core_id[1:0], seq_num[33:2], packet_address[81:34], zero [87:82]
    logic [87:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // add_accepted[0], load_valid[1], load_seq[33:2], load_address[81:34],
    // load_forward_hit[82], retire_valid[83], retire_core[85:84],
    // retire_seq[117:86], retire_address[165:118], all_core_queues_empty[166],
    // zero [167]
    logic [167:0] m_axis_tdata;

    int  fail_count, pending, loads_seen, retires_seen, hits_seen;
    int  idle_cycles = 0;
    int  beats_sent = 0;
    bit  hold_sink = 1'b0;
    bit  sink_free = 1'b0;

    // Small pools of sequence numbers and addresses so completes and loads
    // find matching stores; a few draws fall outside for full-range coverage.
    logic [31:0] seq_pool[8];
    logic [47:0] addr_pool[8];

    always #5 clk = ~clk;

    store_checker_bank_queues_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    scbq_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_user(s_axis_tuser),
        .in_data(s_axis_tdata),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata),
        .fail_count(fail_count), .pending(pending), .loads_seen(loads_seen),
        .retires_seen(retires_seen), .hits_seen(hits_seen)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] pack_user(logic op, logic [1:0] kind);
        return {5'b00000, kind, op};
    endfunction

    function automatic logic [87:0] pack_data(logic [1:0] core, logic [31:0] seq,
                                              logic [47:0] addr);
        return {6'b000000, addr, seq, core};
    endfunction

    function automatic logic [47:0] rand_addr();
        return 48'({$urandom, $urandom});
    endfunction

    // Offer one beat and hold it until accepted.
    task automatic send_beat(logic [7:0] u, logic [87:0] d);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= u;
        s_axis_tdata <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_gap();
        int g;
        g = gap_len();
        if (g != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_add(logic [1:0] kind, logic [1:0] core, logic [31:0] seq,
                            logic [47:0] addr);
        send_beat(pack_user(OP_ADD, kind), pack_data(core, seq, addr));
        send_gap();
    endtask

    task automatic send_tick();
        send_beat(pack_user(OP_TICK, 2'($urandom)),
                  pack_data(2'($urandom), $urandom, rand_addr()));
        send_gap();
    endtask

    // Hold the sender until every expected result has drained.
    task automatic drain_wait();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_seq();
        return ($urandom_range(0, 9) == 0) ? $urandom : seq_pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic [47:0] pick_addr();
        return ($urandom_range(0, 9) == 0) ? rand_addr()
                                           : addr_pool[$urandom_range(0, 7)];
    endfunction

    // Sink side: random stalls, plus a long hold-off requested by stimulus.
    initial
    begin
        int g;
        @(posedge rst_n);
        forever begin
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_sink = 1'b0;
            end
            g = sink_free ? 0 : gap_len();
            m_axis_tready <= (g == 0);
            @(posedge clk);
            if (g > 1)
                repeat (g - 1) @(posedge clk);
        end
    end

    // Watchdog: count cycles without any accepted beat.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [1:0] core;
        logic [31:0] s;
        logic [47:0] a;
        int r;
        for (int i = 0; i < 8; i++) begin
            seq_pool[i] = $urandom;
            addr_pool[i] = rand_addr();
        end
        seq_pool[0] = '0;
        seq_pool[1] = '1;
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tick on empty, unknown kind, field extremes, every kind,
        // forward hit and miss, complete without a match, retirement.
        send_tick();
        send_add(2'd3, 2'd1, '1, '1);
        send_add(KIND_COMMIT, 2'd0, '0, '0);
        send_add(KIND_COMMIT, 2'd3, '1, '1);
        send_add(KIND_LOAD, 2'd3, 32'h1234_5678, '1);
        send_add(KIND_LOAD, 2'd0, 32'h0, 48'h5555_5555_5555);
        send_add(KIND_COMPLETE, 2'd2, 32'hdead_beef, 48'h0);
        send_add(KIND_COMPLETE, 2'd3, '1, 48'h0);
        send_add(KIND_COMPLETE, 2'd0, '0, 48'h0);
        repeat (10) send_tick();
        drain_wait();

        // Fill the main queue past capacity and overflow core 1's queue so a
        // commit waits at the head.
        for (int i = 0; i < 18; i++)
            send_add(KIND_COMMIT, 2'd1, 32'(i), 48'hAAAA_0000_0000 + 48'(i));
        repeat (20) send_tick();
        drain_wait();

        // Long receiver hold-off while the sender keeps offering.
        hold_sink = 1'b1;
        for (int i = 0; i < 30; i++)
            send_add(KIND_COMPLETE, 2'd1, 32'(i), '0);
        repeat (20) send_tick();
        drain_wait();

        // Random: mostly well-formed commit/complete/load traffic with ticks.
        for (int n = 0; n < 450; n++) begin
            sink_free = (n >= 200 && n < 260);
            r = $urandom_range(0, 99);
            core = 2'($urandom);
            s = pick_seq();
            a = pick_addr();
            if (r < 40)
                send_tick();
            else if (r < 62)
                send_add(KIND_COMMIT, core, s, a);
            else if (r < 80)
                send_add(KIND_COMPLETE, core, s, a);
            else if (r < 95)
                send_add(KIND_LOAD, core, s, a);
            else
                send_add(2'($urandom), core, $urandom, rand_addr());
            if (n == 225)
                drain_wait();
        end
        sink_free = 1'b1;
        // Flush remaining work with ticks so ready entries retire.
        for (int i = 0; i < 40; i++)
            send_tick();
        drain_wait();
        repeat (20) @(posedge clk);

        $display("Sent %0d beats: %0d loads (%0d forward hits), %0d retirements checked.",
                 beats_sent, loads_seen, hits_seen, retires_seen);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
